[rtl/particle_sensor_frame_parser_assert.svh]
// Assertion macros shared by the particle sensor frame parser modules.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_ASSERT_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/psfp_pkg.sv]
// Types, constants and the command byte table of the particle sensor frame parser.
package psfp_pkg;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_SLEEP = 2'd1,
    OP_WAKE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CMD     = 2'd0,
    KIND_READING = 2'd1,
    KIND_FAIL    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    JOB_SLEEP    = 2'd0,
    JOB_WAKE     = 2'd1,
    JOB_READINGS = 2'd2,
    JOB_FAIL     = 2'd3
  } job_kind_t;

  // One unit of work handed from the parser to the result sequencer.
  typedef struct packed {
    job_kind_t   kind;
    logic        bank;
    logic [15:0] bad_count;
    logic        asleep;
  } job_t;

  // Frees a reading buffer bank once its last word has been read.
  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  localparam int QUEUE_DEPTH  = 4;
  localparam int NUM_READINGS = 12;
  localparam int CMD_BYTES    = 7;
  localparam int RAM_WIDTH    = 16;
  localparam int RAM_DEPTH    = 32;
  localparam int RAM_AW       = 5;

  localparam logic [7:0] START_BYTE1 = 8'h42;
  localparam logic [7:0] START_BYTE2 = 8'h4D;

  localparam logic [3:0] LAST_READING = 4'(NUM_READINGS - 1);
  localparam logic [3:0] LAST_CMD     = 4'(CMD_BYTES - 1);

  // Seven-byte sensor command; sleep and wake differ in the data and check bytes.
  function automatic logic [7:0] cmd_byte(input logic is_sleep, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h42;
      3'd1:    b = 8'h4D;
      3'd2:    b = 8'hE4;
      3'd3:    b = 8'h00;
      3'd4:    b = is_sleep ? 8'h00 : 8'h01;
      3'd5:    b = 8'h01;
      3'd6:    b = is_sleep ? 8'h73 : 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/psfp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module psfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/psfp_front.sv]
// Front end: accepts words, tracks the frame, checks the sum and queues result jobs.
`include "particle_sensor_frame_parser_assert.svh"

module psfp_front #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          opcode,
  input  logic [7:0]                          rx_byte,
  input  logic                                q_full_i,
  output logic                                push_o,
  output psfp_pkg::job_t                      job_o,
  input  psfp_pkg::release_t                  rel_i,
  output logic                                ram_wr_en,
  output logic [psfp_pkg::RAM_AW-1:0]         ram_wr_addr,
  output logic [psfp_pkg::RAM_WIDTH-1:0]      ram_wr_data
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] SUM_END  = CW'(FRAME_BYTES - 2);

  typedef enum logic [1:0] {
    S_HUNT,
    S_SECOND,
    S_BODY,
    S_SLEEP
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [15:0]   fail_r, fail_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic          accept;
  logic [CW-1:0] pair;
  logic [CW-1:0] ri;
  logic          in_range;

  assign in_ready = !q_full_i && !busy_r[bank_r];
  assign accept   = in_valid && in_ready;

  // Readings live in byte pairs 2..13; each pair becomes one 16-bit buffer word.
  assign pair     = cnt_r >> 1;
  assign ri       = pair - CW'(2);
  assign in_range = pair inside {[CW'(2) : CW'(psfp_pkg::NUM_READINGS + 1)]};

  assign ram_wr_addr = {bank_r, ri[3:0]};
  assign ram_wr_data = cnt_r[0] ? {prev_r, rx_byte} : {rx_byte, 8'h00};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    fail_nxt  = fail_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    push_o    = 1'b0;
    ram_wr_en = 1'b0;
    job_o     = '{kind: psfp_pkg::JOB_FAIL, bank: bank_r, bad_count: fail_r, asleep: 1'b0};

    if (rel_i.en) begin
      busy_nxt[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      case (opcode)
        psfp_pkg::OP_SLEEP: begin
          state_nxt    = S_SLEEP;
          cnt_nxt      = '0;
          push_o       = 1'b1;
          job_o.kind   = psfp_pkg::JOB_SLEEP;
          job_o.asleep = 1'b1;
        end
        psfp_pkg::OP_WAKE: begin
          state_nxt  = S_HUNT;
          cnt_nxt    = '0;
          push_o     = 1'b1;
          job_o.kind = psfp_pkg::JOB_WAKE;
        end
        psfp_pkg::OP_RX: begin
          prev_nxt = rx_byte;
          case (state_r)
            S_HUNT: begin
              if (rx_byte == psfp_pkg::START_BYTE1) begin
                state_nxt = S_SECOND;
                cnt_nxt   = CW'(1);
                sum_nxt   = {8'h00, rx_byte};
              end
            end
            S_SECOND: begin
              if (rx_byte != psfp_pkg::START_BYTE2) begin
                state_nxt = S_HUNT;
                cnt_nxt   = '0;
              end else begin
                state_nxt = S_BODY;
                cnt_nxt   = CW'(2);
                sum_nxt   = sum_r + {8'h00, rx_byte};
              end
            end
            S_BODY: begin
              ram_wr_en = in_range && (cnt_r[0] || (cnt_r == LAST_IDX));
              if (cnt_r < SUM_END) begin
                sum_nxt = sum_r + {8'h00, rx_byte};
              end
              if (cnt_r == LAST_IDX) begin
                state_nxt = S_HUNT;
                cnt_nxt   = '0;
                push_o    = 1'b1;
                if ({prev_r, rx_byte} == sum_r) begin
                  fail_nxt         = 16'h0000;
                  job_o.kind       = psfp_pkg::JOB_READINGS;
                  job_o.bad_count  = 16'h0000;
                  busy_nxt[bank_r] = 1'b1;
                  bank_nxt         = !bank_r;
                end else begin
                  if (fail_r != 16'hFFFF) begin
                    fail_nxt = fail_r + 16'd1;
                  end
                  job_o.bad_count = fail_nxt;
                end
              end else begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
      cnt_r   <= '0;
      sum_r   <= 16'h0000;
      fail_r  <= 16'h0000;
      bank_r  <= 1'b0;
      busy_r  <= 2'b00;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      fail_r  <= fail_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
    prev_r <= prev_nxt;
  end

  `PSFP_ASSERT_NEXT(a_fail_saturates, clk, rst_n, fail_r == 16'hFFFF,
                    (fail_r == 16'hFFFF) || (fail_r == 16'h0000), "failure count wrapped")
  `PSFP_ASSERT_SAME(a_write_free_bank, clk, rst_n, ram_wr_en, !busy_r[bank_r],
                    "buffer write into a bank still being read")

endmodule

[rtl/psfp_queue.sv]
// Short job queue between the parser front end and the result sequencer.
`include "particle_sensor_frame_parser_assert.svh"

module psfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  psfp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output psfp_pkg::job_t data_o
);

  localparam int PW = $clog2(psfp_pkg::QUEUE_DEPTH);

  psfp_pkg::job_t entry_r [psfp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;

  assign full_o  = (count_r == (PW + 1)'(psfp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_r == '0);
  assign data_o  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + (PW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - (PW + 1)'(1);
      end
    end
    if (push_i) begin
      entry_r[wr_ptr_r] <= data_i;
    end
  end

  `PSFP_ASSERT_SAME(a_q_no_overflow, clk, rst_n, push_i, !full_o, "job pushed into a full queue")
  `PSFP_ASSERT_SAME(a_q_no_underflow, clk, rst_n, pop_i, !empty_o, "job popped from an empty queue")

endmodule

[rtl/psfp_back.sv]
// Back end: expands queued jobs into result words and holds the output register.
`include "particle_sensor_frame_parser_assert.svh"

module psfp_back #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty_i,
  input  psfp_pkg::job_t                 q_data_i,
  output logic                           pop_o,
  output psfp_pkg::release_t             rel_o,
  output logic                           ram_rd_en,
  output logic [psfp_pkg::RAM_AW-1:0]    ram_rd_addr,
  input  logic [psfp_pkg::RAM_WIDTH-1:0] ram_rd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_kind,
  output logic [3:0]                     out_index,
  output logic [15:0]                    out_value,
  output logic                           out_last,
  output logic [15:0]                    out_bad,
  output logic                           out_asleep
);

  logic           active_r;
  psfp_pkg::job_t job_r;
  logic [3:0]     step_r;

  logic           out_valid_r;
  logic [1:0]     okind_r;
  logic [3:0]     oidx_r;
  logic [7:0]     obyte_r;
  logic           ozero_r;
  logic           olast_r;
  logic [15:0]    obad_r;
  logic           oasleep_r;

  logic           adv;
  logic           seq_last;
  logic           is_read;
  logic           take;
  logic [1:0]     kind_c;
  logic           zero_c;

  assign adv     = !out_valid_r || out_ready;
  assign is_read = (job_r.kind == psfp_pkg::JOB_READINGS);

  always_comb begin
    case (job_r.kind)
      psfp_pkg::JOB_READINGS: begin
        seq_last = (step_r == psfp_pkg::LAST_READING);
        kind_c   = psfp_pkg::KIND_READING;
      end
      psfp_pkg::JOB_FAIL: begin
        seq_last = 1'b1;
        kind_c   = psfp_pkg::KIND_FAIL;
      end
      default: begin
        seq_last = (step_r == psfp_pkg::LAST_CMD);
        kind_c   = psfp_pkg::KIND_CMD;
      end
    endcase
  end

  // Readings whose bytes lie beyond a short frame read as zero.
  assign zero_c = !is_read || ((int'(step_r) * 2 + 4) >= FRAME_BYTES);

  assign take  = !active_r || (adv && seq_last);
  assign pop_o = take && !q_empty_i;

  assign ram_rd_en   = adv && active_r && is_read;
  assign ram_rd_addr = {job_r.bank, step_r};

  assign rel_o.en   = adv && active_r && is_read && seq_last;
  assign rel_o.bank = job_r.bank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_o) begin
        active_r <= 1'b1;
        step_r   <= 4'd0;
      end else if (adv && active_r) begin
        if (seq_last) begin
          active_r <= 1'b0;
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
      if (adv) begin
        out_valid_r <= active_r;
      end
    end
    if (pop_o) begin
      job_r <= q_data_i;
    end
    if (adv) begin
      okind_r   <= kind_c;
      oidx_r    <= is_read ? step_r : 4'd0;
      obyte_r   <= (job_r.kind inside {psfp_pkg::JOB_SLEEP, psfp_pkg::JOB_WAKE}) ?
                   psfp_pkg::cmd_byte(job_r.kind == psfp_pkg::JOB_SLEEP, step_r[2:0]) : 8'h00;
      ozero_r   <= zero_c;
      olast_r   <= seq_last;
      obad_r    <= job_r.bad_count;
      oasleep_r <= job_r.asleep;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = okind_r;
  assign out_index  = oidx_r;
  assign out_value  = ozero_r ? {8'h00, obyte_r} : ram_rd_data;
  assign out_last   = olast_r;
  assign out_bad    = obad_r;
  assign out_asleep = oasleep_r;

  `PSFP_ASSERT_SAME(a_cmd_step_range, clk, rst_n, active_r && !is_read,
                    step_r <= psfp_pkg::LAST_CMD, "command or failure step out of range")
  `PSFP_ASSERT_SAME(a_fail_is_last, clk, rst_n,
                    out_valid_r && (okind_r == psfp_pkg::KIND_FAIL), olast_r,
                    "failure word not marked last")

endmodule

[rtl/particle_sensor_frame_parser.sv]
// An accepted word's job passes the job queue and job register before its first result
// word is registered. Throughput: one input and one result word per cycle unless the output
// stalls; a command yields 7 words, a good frame 12 and a bad frame 1, in a 4-entry job
// queue; input stalls while it is full or the reading buffer bank being filled is still read.
// Reset (synchronous, rst_n low): hunt for the start byte, counters and queue cleared;
// the reading buffer needs no clearing pass.
module particle_sensor_frame_parser #(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] reading_index, [19:4] value,
                                  // [35:20] bad_frame_count, [36] asleep, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  logic                           q_full;
  logic                           q_empty;
  logic                           push;
  logic                           pop;
  psfp_pkg::job_t                 job_in;
  psfp_pkg::job_t                 job_out;
  psfp_pkg::release_t             rel;
  logic                           ram_wr_en;
  logic [psfp_pkg::RAM_AW-1:0]    ram_wr_addr;
  logic [psfp_pkg::RAM_WIDTH-1:0] ram_wr_data;
  logic                           ram_rd_en;
  logic [psfp_pkg::RAM_AW-1:0]    ram_rd_addr;
  logic [psfp_pkg::RAM_WIDTH-1:0] ram_rd_data;
  logic [3:0]                     out_index;
  logic [15:0]                    out_value;
  logic [15:0]                    out_bad;
  logic                           out_asleep;

  psfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .opcode      (in_tuser),
    .rx_byte     (in_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job_in),
    .rel_i       (rel),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  psfp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  psfp_ram #(
    .WIDTH (psfp_pkg::RAM_WIDTH),
    .DEPTH (psfp_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  psfp_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_data_i    (job_out),
    .pop_o       (pop),
    .rel_o       (rel),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_index   (out_index),
    .out_value   (out_value),
    .out_last    (out_tlast),
    .out_bad     (out_bad),
    .out_asleep  (out_asleep)
  );

  assign out_tdata = {3'b000, out_asleep, out_bad, out_value, out_index};

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the particle sensor frame parser.
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAME_LEN          = 32;
  localparam int READINGS           = 12;
  localparam int WORD_TARGET        = 400;
  localparam int TAIL_WORDS         = 60;
  localparam int LONG_HOLD          = 300;
  localparam int HOLD_AFTER_RESULTS = 30;
  localparam int DRAIN_CYCLES       = 20;
  localparam int WATCHDOG_LIMIT     = 3000;

  typedef enum logic [1:0] {
    P_HUNT,
    P_SECOND,
    P_BODY,
    P_SLEEP
  } parse_state_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct packed {
    psfp_pkg::opcode_t op;
    logic [7:0]        data;
  } sensor_word_t;

  typedef struct packed {
    psfp_pkg::kind_t kind;
    logic [3:0]      idx;
    logic [15:0]     value;
    logic            last;
    logic [15:0]     bad_cnt;
    logic            asleep;
  } sensor_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = psfp_pkg::OP_RX;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  particle_sensor_frame_parser #(
    .FRAME_BYTES(FRAME_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Predictor state, starting in its reset values.
  parse_state_t pst       = P_HUNT;
  int unsigned  nbytes    = 0;
  logic [15:0]  csum      = '0;
  logic [7:0]   frame [FRAME_LEN];
  logic [15:0]  fail_cnt  = '0;

  logic [7:0] sleep_seq [7] = '{8'h42, 8'h4D, 8'hE4, 8'h00, 8'h00, 8'h01, 8'h73};
  logic [7:0] wake_seq  [7] = '{8'h42, 8'h4D, 8'hE4, 8'h00, 8'h01, 8'h01, 8'h74};

  sensor_word_t   tx_words [$];
  sensor_result_t due_results [$];

  int unsigned total_words  = 0;
  int unsigned words_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  function automatic void push_result(psfp_pkg::kind_t kind, logic [3:0] idx,
                                      logic [15:0] value, logic last);
    sensor_result_t r;
    r.kind    = kind;
    r.idx     = idx;
    r.value   = value;
    r.last    = last;
    r.bad_cnt = fail_cnt;
    r.asleep  = (pst == P_SLEEP);
    due_results.push_back(r);
  endfunction

  function automatic void send_command(logic is_sleep);
    for (int i = 0; i < 7; i++)
      push_result(psfp_pkg::KIND_CMD, 4'd0,
                  {8'h00, is_sleep ? sleep_seq[i] : wake_seq[i]}, i == 6);
  endfunction

  // Advances the parser state by one word and queues the results it causes.
  function automatic void parse_word(psfp_pkg::opcode_t op, logic [7:0] b);
    logic [15:0] chk;
    case (op)
      psfp_pkg::OP_SLEEP: begin
        pst    = P_SLEEP;
        nbytes = 0;
        send_command(1'b1);
      end
      psfp_pkg::OP_WAKE: begin
        pst    = P_HUNT;
        nbytes = 0;
        send_command(1'b0);
      end
      psfp_pkg::OP_RX: begin
        case (pst)
          P_HUNT: begin
            if (b == psfp_pkg::START_BYTE1) begin
              frame[0] = b;
              nbytes   = 1;
              csum     = {8'h00, b};
              pst      = P_SECOND;
            end
          end
          P_SECOND: begin
            // A wrong second byte is dropped, not retried as a start byte.
            if (b != psfp_pkg::START_BYTE2) begin
              pst    = P_HUNT;
              nbytes = 0;
            end else begin
              frame[1] = b;
              nbytes   = 2;
              csum     = csum + {8'h00, b};
              pst      = P_BODY;
            end
          end
          P_BODY: begin
            frame[nbytes] = b;
            if (nbytes < FRAME_LEN - 2)
              csum = csum + {8'h00, b};
            nbytes++;
            if (nbytes == FRAME_LEN) begin
              pst    = P_HUNT;
              nbytes = 0;
              chk    = {frame[FRAME_LEN-2], frame[FRAME_LEN-1]};
              if (chk == csum) begin
                fail_cnt = '0;
                for (int i = 0; i < READINGS; i++)
                  push_result(psfp_pkg::KIND_READING, 4'(i),
                              {frame[4+2*i], frame[5+2*i]}, i == READINGS - 1);
              end else begin
                if (fail_cnt != 16'hFFFF)
                  fail_cnt++;
                push_result(psfp_pkg::KIND_FAIL, 4'd0, 16'd0, 1'b1);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic add_word(input psfp_pkg::opcode_t op, input logic [7:0] b);
    sensor_word_t w;
    w.op   = op;
    w.data = b;
    tx_words.push_back(w);
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n)
      add_word(psfp_pkg::OP_RX,
               ($urandom_range(0, 3) == 0) ? psfp_pkg::START_BYTE1 : 8'($urandom));
  endtask

  // Builds a frame with a correct or corrupted checksum and sends its first keep bytes.
  task automatic add_frame(input bit good, input fill_t fill, input int unsigned keep);
    logic [7:0]  fb [FRAME_LEN];
    logic [15:0] sum;
    sum   = '0;
    fb[0] = psfp_pkg::START_BYTE1;
    fb[1] = psfp_pkg::START_BYTE2;
    for (int i = 2; i < FRAME_LEN - 2; i++)
      fb[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    for (int i = 0; i < FRAME_LEN - 2; i++)
      sum = sum + {8'h00, fb[i]};
    if (!good)
      sum = sum ^ 16'($urandom_range(1, 65535));
    fb[FRAME_LEN-2] = sum[15:8];
    fb[FRAME_LEN-1] = sum[7:0];
    for (int i = 0; i < keep; i++)
      add_word(psfp_pkg::OP_RX, fb[i]);
  endtask

  // Sender: words come from tx_words, with random gaps until the tail of the run.
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    sensor_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_word(psfp_pkg::opcode_t'(in_tuser), in_tdata);
        words_taken <= words_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (words_taken + TAIL_WORDS < total_words && $urandom_range(0, 9) == 0) begin
          in_gap    <= $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else if (tx_words.size() != 0) begin
          w = tx_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= w.data;
          in_tuser  <= w.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up to its input.
  int unsigned out_gap   = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
      hold_done  <= 1'b1;
      hold_left  <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (words_taken + TAIL_WORDS < total_words && $urandom_range(0, 7) == 0) begin
      out_gap    <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: every result word is matched against the oldest expectation.
  always @(posedge clk) begin
    sensor_result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (due_results.size() == 0) begin
        $error("unexpected result word: kind %0d, value %0d", out_tuser, out_tdata[19:4]);
        mismatches++;
      end else begin
        r = due_results.pop_front();
        check_field("kind", 16'(r.kind), 16'(out_tuser));
        check_field("reading_index", 16'(r.idx), 16'(out_tdata[3:0]));
        check_field("value", r.value, out_tdata[19:4]);
        check_field("last", 16'(r.last), 16'(out_tlast));
        check_field("bad_frame_count", r.bad_cnt, out_tdata[35:20]);
        check_field("asleep", 16'(r.asleep), 16'(out_tdata[36]));
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** particle_sensor_frame_parser: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;

    // Directed words: ignored opcode, stray bytes, broken start, sleep and wake.
    add_word(psfp_pkg::OP_NONE, 8'hFF);
    add_word(psfp_pkg::OP_NONE, 8'h00);
    add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE2);
    add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE1);
    add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE1);
    add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE2);
    add_word(psfp_pkg::OP_WAKE, 8'h00);
    add_word(psfp_pkg::OP_SLEEP, 8'hFF);
    add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE1);
    add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE2);
    add_word(psfp_pkg::OP_RX, 8'hFF);
    add_word(psfp_pkg::OP_NONE, 8'h5A);
    add_word(psfp_pkg::OP_WAKE, 8'hA5);
    // A command in the middle of a frame drops the partial frame.
    add_frame(1'b1, FILL_RANDOM, 7);
    add_word(psfp_pkg::OP_WAKE, 8'h00);
    add_frame(1'b1, FILL_ONES, FRAME_LEN);
    add_frame(1'b1, FILL_ZERO, FRAME_LEN);
    add_frame(1'b0, FILL_RANDOM, FRAME_LEN);
    add_frame(1'b0, FILL_ONES, FRAME_LEN);
    add_frame(1'b1, FILL_RANDOM, FRAME_LEN);

    // Mostly random good frames, plus noise, broken frames, commands and ignored words.
    while (tx_words.size() < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_frame(1'b1, FILL_RANDOM, FRAME_LEN);
      end else if (pick < 54) begin
        add_frame(1'b1, fill_t'($urandom_range(1, 2)), FRAME_LEN);
      end else if (pick < 68) begin
        add_frame(1'b0, FILL_RANDOM, FRAME_LEN);
      end else if (pick < 76) begin
        add_frame(1'($urandom_range(0, 1)), FILL_RANDOM, $urandom_range(1, FRAME_LEN - 1));
      end else if (pick < 84) begin
        add_noise($urandom_range(1, 6));
      end else if (pick < 88) begin
        add_word(psfp_pkg::OP_NONE, 8'($urandom));
      end else if (pick < 94) begin
        add_word(psfp_pkg::OP_SLEEP, 8'($urandom));
        if ($urandom_range(0, 1) == 0)
          add_frame(1'b1, FILL_RANDOM, FRAME_LEN);
        else
          add_noise($urandom_range(1, 6));
        add_word(psfp_pkg::OP_WAKE, 8'($urandom));
      end else begin
        add_word(psfp_pkg::OP_RX, psfp_pkg::START_BYTE1);
        add_word(psfp_pkg::OP_RX, 8'($urandom_range(0, 255)) ^
                 (($urandom_range(0, 1) == 0) ? 8'h00 : 8'h80));
      end
    end
    total_words = tx_words.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken != total_words || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("** particle_sensor_frame_parser: PASSED **");
    else
      $display("** particle_sensor_frame_parser: FAILED **");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/psfp_pkg.sv
rtl/psfp_ram.sv
rtl/psfp_front.sv
rtl/psfp_queue.sv
rtl/psfp_back.sv
rtl/particle_sensor_frame_parser.sv
tb/tb_top.sv
